// ===== hw/rtl/ajbgm_pkg.sv =====
package ajbgm_pkg;

   localparam int KIND_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int BLK_W     = 13;
   localparam int MIX_W     = 24;
   localparam int SMP_W     = 16;
   localparam int VOL_W     = 16;
   localparam int COEF_W    = 16;
   localparam int LVL_W     = 17;
   localparam int GAIN_W    = 31;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REQ_DW    = 72;
   localparam int REQ_UW    = 3;
   localparam int RSP_DW    = 48;

   localparam logic [VOL_W:0]  VOL_ONE  = 17'd32768;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 31'h4000_0000;
   localparam logic signed [MIX_W-1:0] MIX_MAX = 24'sh7F_FFFF;
   localparam logic signed [MIX_W-1:0] MIX_MIN = -24'sh80_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 2'd0,
      KIND_PULL = 2'd1,
      KIND_GONE = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_VOLUME = 3'd0,
      REG_COEF   = 3'd1,
      REG_PRIME  = 3'd2,
      REG_HIGH   = 3'd3,
      REG_RUN    = 3'd4,
      REG_STEREO = 3'd5
   } reg_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH, S_CLEAR, S_BLOCK, S_READ, S_GAIN, S_GNEW, S_MIX, S_OUT
   } state_type;

   typedef struct packed {
      logic [VOL_W-1:0]  volume;
      logic [COEF_W-1:0] coef;
      logic [LVL_W-1:0]  prime;
      logic [LVL_W-1:0]  high;
      logic              running;
      logic              stereo;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic push;
      logic clear;
      logic block;
      logic read;
      logic gain_mul;
      logic gain_upd;
      logic mix_mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
   } sts_type;

endpackage

// ===== hw/rtl/ajbgm_csr.sv =====
module ajbgm_csr
   import ajbgm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   logic    wr;
   reg_type idx;

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume  <= 16'd32768;
         cfg_ff.coef    <= 16'd68;
         cfg_ff.prime   <= 17'd4800;
         cfg_ff.high    <= 17'd48000;
         cfg_ff.running <= 1'b0;
         cfg_ff.stereo  <= 1'b1;
      end else if (wr) begin
         case (idx)
            REG_VOLUME: cfg_ff.volume  <= csr_pwdata[VOL_W-1:0];
            REG_COEF:   cfg_ff.coef    <= csr_pwdata[COEF_W-1:0];
            REG_PRIME:  cfg_ff.prime   <= csr_pwdata[LVL_W-1:0];
            REG_HIGH:   cfg_ff.high    <= csr_pwdata[LVL_W-1:0];
            REG_RUN:    cfg_ff.running <= csr_pwdata[0];
            REG_STEREO: cfg_ff.stereo  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_VOLUME: csr_prdata = CSR_DW'(cfg_ff.volume);
         REG_COEF:   csr_prdata = CSR_DW'(cfg_ff.coef);
         REG_PRIME:  csr_prdata = CSR_DW'(cfg_ff.prime);
         REG_HIGH:   csr_prdata = CSR_DW'(cfg_ff.high);
         REG_RUN:    csr_prdata = CSR_DW'(cfg_ff.running);
         REG_STEREO: csr_prdata = CSR_DW'(cfg_ff.stereo);
         default:    csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/ajbgm_ctrl.sv =====
module ajbgm_ctrl
   import ajbgm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_accept,
   input  sts_type sts,
   output logic    idle,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      idle     = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               case (sts.kind)
                  KIND_PUSH: state_in = S_PUSH;
                  KIND_PULL: state_in = S_BLOCK;
                  KIND_GONE: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         S_BLOCK: begin
            cmd.block = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            cmd.gain_mul = 1'b1;
            state_in     = S_GNEW;
         end
         S_GNEW: begin
            cmd.gain_upd = 1'b1;
            state_in     = S_MIX;
         end
         S_MIX: begin
            cmd.mix_mul = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/ajbgm_dp.sv =====
module ajbgm_dp
   import ajbgm_pkg::*;
#(
   parameter int FIFO_FRAMES = 65536,
   parameter int MAX_BLOCK   = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [REQ_UW-1:0]        req_tuser,
   input  logic [REQ_DW-1:0]        req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DW-1:0]        rsp_tdata,
   output logic                     rsp_tuser
);

   localparam int PTR_W  = $clog2(FIFO_FRAMES);
   localparam int FILL_W = $clog2(FIFO_FRAMES + 1);
   localparam int FTS_W  = $clog2(MAX_BLOCK + 1);
   localparam int CMP_W  = 32;

   logic [2*SMP_W-1:0] mem [FIFO_FRAMES];
   logic [2*SMP_W-1:0] rd_word_ff;

   logic                     first_ff;
   logic [BYTE_W-1:0]        byte_ff;
   logic [BLK_W-1:0]         blk_ff;
   logic signed [MIX_W-1:0]  dry_l_ff, dry_r_ff;

   logic [PTR_W-1:0]   wp_ff, rp_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [23:0]        part_ff;
   logic [1:0]         pc_ff;
   logic               primed_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [FTS_W-1:0]   fts_ff;
   logic               serve_ff;
   logic [GAIN_W-1:0]  target_ff;
   logic signed [48:0] gprod_ff;
   logic               rsp_valid_ff;
   logic signed [MIX_W-1:0] out_l_ff, out_r_ff;
   logic               out_s_ff;

   logic [CMP_W-1:0]   fill_x, n_x;
   logic               drop;
   logic [VOL_W:0]     vsat;
   logic signed [32:0] step;
   logic signed [33:0] gnew;
   logic signed [SMP_W-1:0] sl, sr;
   logic signed [SMP_W:0]   smono;
   logic signed [31:0] gs;

   assign sts.kind     = kind_type'(req_tuser[1:0]);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {out_r_ff, out_l_ff};
   assign rsp_tuser    = out_s_ff;

   assign fill_x = CMP_W'(fill_ff);
   assign n_x    = (CMP_W'(blk_ff) > CMP_W'(MAX_BLOCK)) ? CMP_W'(MAX_BLOCK) : CMP_W'(blk_ff);
   assign drop   = (fill_x > CMP_W'(cfg.high)) || (fill_x >= CMP_W'(FIFO_FRAMES));
   assign vsat   = ({1'b0, cfg.volume} > VOL_ONE) ? VOL_ONE : {1'b0, cfg.volume};
   assign sl     = signed'(rd_word_ff[SMP_W-1:0]);
   assign sr     = signed'(rd_word_ff[2*SMP_W-1:SMP_W]);
   assign smono  = 17'(sl) + 17'(sr);
   assign gs     = signed'({1'b0, gain_ff});
   assign step   = 33'((gprod_ff + 49'sd32768) >>> 16);
   assign gnew   = 34'(signed'({1'b0, gain_ff})) + 34'(step);

   always_ff @(posedge clock) begin
      if (cmd.push && pc_ff == 2'd3 && !drop) mem[wp_ff] <= {byte_ff, part_ff};
      if (cmd.read) rd_word_ff <= mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff <= req_tuser[2];
         byte_ff  <= req_tdata[7:0];
         blk_ff   <= req_tdata[20:8];
         dry_l_ff <= signed'(req_tdata[44:21]);
         dry_r_ff <= signed'(req_tdata[68:45]);
      end
      if (cmd.read) target_ff <= GAIN_W'({15'd0, vsat} * {15'd0, vsat});
      if (cmd.gain_mul)
         gprod_ff <= 49'(signed'({1'b0, target_ff}) - gs) * 49'(signed'({1'b0, cfg.coef}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         part_ff      <= '0;
         pc_ff        <= '0;
         primed_ff    <= 1'b0;
         gain_ff      <= '0;
         fts_ff       <= '0;
         serve_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load)                    rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (cmd.push) begin
            case (pc_ff)
               2'd0: begin part_ff[7:0]   <= byte_ff; pc_ff <= 2'd1; end
               2'd1: begin part_ff[15:8]  <= byte_ff; pc_ff <= 2'd2; end
               2'd2: begin part_ff[23:16] <= byte_ff; pc_ff <= 2'd3; end
               default: begin
                  part_ff <= '0;
                  pc_ff   <= '0;
                  if (!drop) begin
                     wp_ff   <= (wp_ff == PTR_W'(FIFO_FRAMES - 1)) ? '0 : wp_ff + 1'b1;
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            endcase
         end
         if (cmd.clear) begin
            part_ff <= '0;
            pc_ff   <= '0;
         end
         if (cmd.block && first_ff) begin
            if (!cfg.running) begin
               fts_ff    <= '0;
               primed_ff <= 1'b0;
               gain_ff   <= '0;
               fill_ff   <= '0;
               rp_ff     <= wp_ff;
            end else if (primed_ff || fill_x >= CMP_W'(cfg.prime)) begin
               // underrun serves what is there and drops priming
               primed_ff <= (fill_x >= n_x);
               fts_ff    <= (fill_x < n_x) ? FTS_W'(fill_ff) : FTS_W'(n_x);
            end else begin
               fts_ff <= '0;
            end
         end
         if (cmd.read) begin
            serve_ff <= (fts_ff != '0) && (fill_ff != '0);
            if ((fts_ff != '0) && (fill_ff != '0)) begin
               rp_ff   <= (rp_ff == PTR_W'(FIFO_FRAMES - 1)) ? '0 : rp_ff + 1'b1;
               fill_ff <= fill_ff - 1'b1;
               fts_ff  <= fts_ff - 1'b1;
            end
         end
         if (cmd.gain_upd && serve_ff) begin
            if (gnew < 34'sd0)                          gain_ff <= '0;
            else if (gnew > 34'(signed'({1'b0, GAIN_ONE}))) gain_ff <= GAIN_ONE;
            else                                        gain_ff <= GAIN_W'(gnew);
         end
      end
   end

   // sample products are formed from the freshly updated gain
   logic signed [48:0] pl_next, pr_next;

   assign pl_next = cfg.stereo ? 49'(sl) * 49'(gs) : 49'(smono) * 49'(gs);
   assign pr_next = 49'(sr) * 49'(gs);

   logic signed [48:0] ml_ff, mr_ff;

   always_ff @(posedge clock) begin
      if (cmd.mix_mul) begin
         ml_ff <= pl_next;
         mr_ff <= pr_next;
      end
   end

   logic signed [26:0] fin_l, fin_r;

   assign fin_l = cfg.stereo ? 27'(dry_l_ff) + 27'((ml_ff + 49'sd536870912) >>> 30)
                             : 27'(dry_l_ff) + 27'((ml_ff + 49'sd1073741824) >>> 31);
   assign fin_r = 27'(dry_r_ff) + 27'((mr_ff + 49'sd536870912) >>> 30);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_s_ff <= serve_ff;
         if (!serve_ff) begin
            out_l_ff <= dry_l_ff;
            out_r_ff <= dry_r_ff;
         end else begin
            out_l_ff <= (fin_l > 27'(MIX_MAX)) ? MIX_MAX :
                        (fin_l < 27'(MIX_MIN)) ? MIX_MIN : MIX_W'(fin_l);
            if (cfg.stereo)
               out_r_ff <= (fin_r > 27'(MIX_MAX)) ? MIX_MAX :
                           (fin_r < 27'(MIX_MIN)) ? MIX_MIN : MIX_W'(fin_r);
            else
               out_r_ff <= dry_r_ff;
         end
      end
   end

endmodule

// ===== hw/rtl/audio_jitter_buffer_gain_mixer.sv =====
// Sequencing: req_tready is low while a word is in progress, so a new word is taken only
// once the sequencer is idle again. A pull word steps through block start, read, gain ramp
// multiply, gain update, sample multiply and output load in turn; output load waits while
// rsp is stalled. A push or writer-gone word takes a single step.
// Reset: synchronous, active high; clears pointers, fill, carry, priming, gain and registers.
// The frame store is not cleared; only written entries are ever read.
module audio_jitter_buffer_gain_mixer
   import ajbgm_pkg::*;
#(
   parameter int FIFO_FRAMES = 65536,
   parameter int MAX_BLOCK   = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // byte_value, block_frames, dry_left, dry_right, zero pad
   input  logic [REQ_DW-1:0] req_tdata,
   // kind, first_of_block
   input  logic [REQ_UW-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_left, out_right
   output logic [RSP_DW-1:0] rsp_tdata,
   // served
   output logic              rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    idle;

   assign req_tready = idle;

   ajbgm_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   ajbgm_ctrl u_ctrl (
      .clock, .reset, .req_accept(req_tvalid && idle), .sts, .idle, .cmd
   );

   ajbgm_dp #(.FIFO_FRAMES(FIFO_FRAMES), .MAX_BLOCK(MAX_BLOCK)) u_dp (
      .clock, .reset, .cfg, .cmd, .sts, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

endmodule

// ===== hw/rtl/ajbgm_checker.sv =====
module ajbgm_checker
   import ajbgm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_UW-1:0] req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[1:0] != KIND_NONE) |=> !req_tready)
      else $error("word taken while busy");

   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

endmodule

bind audio_jitter_buffer_gain_mixer ajbgm_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .req_tuser,
   .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);
